[src/pbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pbt_pkg;

    // Sizes of the store and of the sequence.
    localparam int MAX_ITEMS   = 4096;
    localparam int VALUE_BITS  = 19;
    localparam int PATH_NODES  = VALUE_BITS + 1;
    localparam int STORE_DEPTH = 1 + MAX_ITEMS * PATH_NODES;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
    localparam int IDX_BITS    = 13;
    localparam int LVL_BITS    = $clog2(PATH_NODES);
    localparam int NODE_BITS   = CNT_BITS + 2 * ADDR_BITS;

    // One trie node: count of values below it and the two child addresses.
    typedef struct packed {
        logic [CNT_BITS-1:0]             count;
        logic [1:0][ADDR_BITS-1:0]       next;
    } node_t;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_XOR    = 3'd1,
        OP_POP    = 3'd2,
        OP_RANK   = 3'd3,
        OP_SELECT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_RANGE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_CLIPPED   = 3'd3,
        STAT_BAD_K     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q_RA,
        S_Q_RB,
        S_Q_CAP,
        S_L_RA,
        S_L_RB,
        S_L_DEC,
        S_Q_FIN,
        S_P_RD,
        S_P_WR,
        S_DONE
    } state_t;

    // Result handed from the engine to the output register.
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] answer;
        status_t               status;
    } result_t;

    // First node address of a version.
    function automatic logic [ADDR_BITS-1:0] root_of(input logic [IDX_BITS-1:0] version);
        root_of = ADDR_BITS'(version) * ADDR_BITS'(PATH_NODES) + ADDR_BITS'(1);
    endfunction

endpackage

`default_nettype wire

[src/pbt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/pbt_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module pbt_engine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [2:0]                      opcode,
    input  wire logic [pbt_pkg::VALUE_BITS-1:0]  value,
    input  wire logic [pbt_pkg::IDX_BITS-1:0]    left_index,
    input  wire logic [pbt_pkg::IDX_BITS-1:0]    right_index,
    input  wire logic [pbt_pkg::IDX_BITS-1:0]    amount,
    output logic                                 rd_en,
    output logic [pbt_pkg::ADDR_BITS-1:0]        rd_addr,
    input  wire logic [pbt_pkg::NODE_BITS-1:0]   rd_data,
    output logic                                 wr_en,
    output logic [pbt_pkg::ADDR_BITS-1:0]        wr_addr,
    output logic [pbt_pkg::NODE_BITS-1:0]        wr_data,
    output pbt_pkg::result_t                     res,
    input  wire logic                            res_ready
);

    localparam int VB = pbt_pkg::VALUE_BITS;
    localparam int AB = pbt_pkg::ADDR_BITS;
    localparam int CB = pbt_pkg::CNT_BITS;
    localparam int IB = pbt_pkg::IDX_BITS;
    localparam int LB = pbt_pkg::LVL_BITS;

    pbt_pkg::state_t  state_reg, state_next;
    pbt_pkg::op_t     op_reg, op_next;
    pbt_pkg::status_t status_reg, status_next;
    logic [IB-1:0]    len_reg, len_next;
    logic [IB-1:0]    amt_reg, amt_next;
    logic [VB-1:0]    key_reg, key_next;
    logic [VB-1:0]    acc_reg, acc_next;
    logic [LB-1:0]    level_reg, level_next;
    logic [AB-1:0]    pa_reg, pa_next;
    logic [AB-1:0]    pb_reg, pb_next;
    logic [AB-1:0]    wptr_reg, wptr_next;
    pbt_pkg::node_t   node_a_reg, node_a_next;
    pbt_pkg::node_t   node_b_reg, node_b_next;
    pbt_pkg::node_t   ca_reg, ca_next;
    logic             t_reg, t_next;
    logic             forced_reg, forced_next;
    logic             zero_reg, zero_next;

    pbt_pkg::node_t   rdm;
    pbt_pkg::node_t   wnode;
    logic [IB-1:0]    span;
    logic [CB-1:0]    zr;
    logic [VB-1:0]    key_sh;
    logic             kbit;
    logic             num;

    // Node zero and addresses past the store read as the empty node.
    assign rdm    = zero_reg ? '0 : pbt_pkg::node_t'(rd_data);
    assign span   = right_index - left_index + IB'(1);
    assign zr     = ca_reg.count - rdm.count;
    assign kbit   = key_reg[VB-1];
    assign key_sh = key_reg << 1;

    // Control state and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbt_pkg::S_IDLE;
            len_reg   <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        amt_reg    <= amt_next;
        key_reg    <= key_next;
        acc_reg    <= acc_next;
        level_reg  <= level_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        wptr_reg   <= wptr_next;
        node_a_reg <= node_a_next;
        node_b_reg <= node_b_next;
        ca_reg     <= ca_next;
        t_reg      <= t_next;
        forced_reg <= forced_next;
    end

    // Sequencer: decode, query descent and push path copy.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        len_next    = len_reg;
        amt_next    = amt_reg;
        key_next    = key_reg;
        acc_next    = acc_reg;
        level_next  = level_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        wptr_next   = wptr_reg;
        node_a_next = node_a_reg;
        node_b_next = node_b_reg;
        ca_next     = ca_reg;
        t_next      = t_reg;
        forced_next = forced_reg;
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = wptr_reg;
        wnode       = rdm;
        num         = 1'b0;
        res.valid   = 1'b0;
        res.answer  = acc_reg;
        res.status  = status_reg;

        case (state_reg)
            pbt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = pbt_pkg::op_t'(opcode);
                    key_next    = value;
                    amt_next    = amount;
                    acc_next    = '0;
                    level_next  = '0;
                    forced_next = 1'b0;
                    status_next = pbt_pkg::STAT_OK;
                    state_next  = pbt_pkg::S_DONE;
                    case (pbt_pkg::op_t'(opcode))
                        pbt_pkg::OP_PUSH:
                        begin
                            if (len_reg >= IB'(pbt_pkg::MAX_ITEMS))
                            begin
                                status_next = pbt_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wptr_next  = pbt_pkg::root_of(len_reg);
                                pa_next    = (len_reg == '0) ? '0 :
                                             pbt_pkg::root_of(len_reg - IB'(1));
                                state_next = pbt_pkg::S_P_RD;
                            end
                        end
                        pbt_pkg::OP_POP:
                        begin
                            if (amount > len_reg)
                            begin
                                len_next    = '0;
                                status_next = pbt_pkg::STAT_CLIPPED;
                            end
                            else
                            begin
                                len_next = len_reg - amount;
                            end
                        end
                        pbt_pkg::OP_XOR, pbt_pkg::OP_RANK, pbt_pkg::OP_SELECT:
                        begin
                            if (left_index == '0 || left_index > right_index ||
                                right_index > len_reg)
                            begin
                                status_next = pbt_pkg::STAT_BAD_RANGE;
                            end
                            else if (pbt_pkg::op_t'(opcode) == pbt_pkg::OP_SELECT &&
                                     (amount == '0 || amount > span))
                            begin
                                status_next = pbt_pkg::STAT_BAD_K;
                            end
                            else
                            begin
                                pa_next    = pbt_pkg::root_of(right_index - IB'(1));
                                pb_next    = (left_index == IB'(1)) ? '0 :
                                             pbt_pkg::root_of(left_index - IB'(2));
                                state_next = pbt_pkg::S_Q_RA;
                            end
                        end
                        default:
                        begin
                            status_next = pbt_pkg::STAT_OK;
                        end
                    endcase
                end
            end

            // Fetch the two version roots.
            pbt_pkg::S_Q_RA:
            begin
                rd_en      = 1'b1;
                rd_addr    = pa_reg;
                state_next = pbt_pkg::S_Q_RB;
            end
            pbt_pkg::S_Q_RB:
            begin
                node_a_next = rdm;
                rd_en       = 1'b1;
                rd_addr     = pb_reg;
                state_next  = pbt_pkg::S_Q_CAP;
            end
            pbt_pkg::S_Q_CAP:
            begin
                node_b_next = rdm;
                t_next      = (op_reg == pbt_pkg::OP_XOR) ? ~kbit : 1'b0;
                state_next  = pbt_pkg::S_L_RA;
            end

            // One level: read both children on side t, then decide.
            pbt_pkg::S_L_RA:
            begin
                rd_en      = 1'b1;
                rd_addr    = node_a_reg.next[t_reg];
                state_next = pbt_pkg::S_L_RB;
            end
            pbt_pkg::S_L_RB:
            begin
                ca_next    = rdm;
                rd_en      = 1'b1;
                rd_addr    = node_b_reg.next[t_reg];
                state_next = pbt_pkg::S_L_DEC;
            end
            pbt_pkg::S_L_DEC:
            begin
                if (forced_reg)
                begin
                    num = t_reg;
                end
                else
                begin
                    case (op_reg)
                        pbt_pkg::OP_XOR:
                        begin
                            num      = (ca_reg.count <= rdm.count) ? ~t_reg : t_reg;
                            acc_next = {acc_reg[VB-2:0], num};
                        end
                        pbt_pkg::OP_RANK:
                        begin
                            num = kbit;
                            if (kbit)
                            begin
                                acc_next = acc_reg + VB'(zr);
                            end
                        end
                        default:
                        begin
                            num = (amt_reg > IB'(zr));
                            if (num)
                            begin
                                amt_next = amt_reg - IB'(zr);
                            end
                            acc_next = {acc_reg[VB-2:0], num};
                        end
                    endcase
                end
                if (num != t_reg)
                begin
                    // Other side wanted: fetch its children and descend.
                    t_next      = num;
                    forced_next = 1'b1;
                    state_next  = pbt_pkg::S_L_RA;
                end
                else
                begin
                    node_a_next = ca_reg;
                    node_b_next = rdm;
                    key_next    = key_sh;
                    forced_next = 1'b0;
                    level_next  = level_reg + LB'(1);
                    t_next      = (op_reg == pbt_pkg::OP_XOR) ? ~key_sh[VB-1] : 1'b0;
                    state_next  = (level_reg == LB'(VB - 1)) ? pbt_pkg::S_Q_FIN :
                                  pbt_pkg::S_L_RA;
                end
            end
            pbt_pkg::S_Q_FIN:
            begin
                if (op_reg == pbt_pkg::OP_RANK)
                begin
                    acc_next = acc_reg + VB'(node_a_reg.count - node_b_reg.count);
                end
                state_next = pbt_pkg::S_DONE;
            end

            // Push: copy the previous path node by node, a read and then a write per node.
            pbt_pkg::S_P_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pa_reg;
                state_next = pbt_pkg::S_P_WR;
            end
            pbt_pkg::S_P_WR:
            begin
                wnode.count = rdm.count + CB'(1);
                wr_en       = 1'b1;
                if (level_reg == LB'(VB))
                begin
                    len_next   = len_reg + IB'(1);
                    state_next = pbt_pkg::S_DONE;
                end
                else
                begin
                    pa_next          = rdm.next[kbit];
                    wnode.next[kbit] = wptr_reg + AB'(1);
                    wptr_next        = wptr_reg + AB'(1);
                    key_next         = key_sh;
                    level_next       = level_reg + LB'(1);
                    state_next       = pbt_pkg::S_P_RD;
                end
            end

            pbt_pkg::S_DONE:
            begin
                res.valid = 1'b1;
                if (op_reg != pbt_pkg::OP_XOR && op_reg != pbt_pkg::OP_RANK &&
                    op_reg != pbt_pkg::OP_SELECT)
                begin
                    res.answer = '0;
                end
                if (status_reg != pbt_pkg::STAT_OK)
                begin
                    res.answer = '0;
                end
                if (res_ready)
                begin
                    state_next = pbt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pbt_pkg::S_IDLE;
            end
        endcase
    end

    assign wr_data   = wnode;
    assign zero_next = rd_en && (rd_addr == '0 || rd_addr >= AB'(pbt_pkg::STORE_DEPTH));

    // The sentinel node is never overwritten.
    a_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr != '0)
        else $error("write to the sentinel node");

    // A push writes only the fresh path, never the node it reads.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> $past(rd_addr) != wr_addr || $past(rd_addr) == '0)
        else $error("push path overwrote its source node");

    // The sequence never grows beyond its capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= IB'(pbt_pkg::MAX_ITEMS))
        else $error("sequence length above capacity");

    // Length changes only when an operation completes its work.
    a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != $past(len_reg)) |-> ($past(state_reg) == pbt_pkg::S_IDLE ||
                                        $past(state_reg) == pbt_pkg::S_P_WR))
        else $error("length changed mid-operation");

endmodule

`default_nettype wire

[src/persistent_bit_trie_range_query_top.sv]
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_ready   opcode, value, left_index, right_index, amount
// output   out        out_valid / out_ready answer, status
//
// Push does a read and then a write per path node on the store.
// Queries do two child reads per level, four when the walk turns to the other side.
// Pop, a full push, bad ranges, a bad k and unknown opcodes go straight from decode to the result.
// Reset clears the length; node zero is decoded as the empty node, no clearing pass.
// A new transfer is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module persistent_bit_trie_range_query_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [2:0]                      opcode,
    input  wire logic [pbt_pkg::VALUE_BITS-1:0]  value,
    input  wire logic [pbt_pkg::IDX_BITS-1:0]    left_index,
    input  wire logic [pbt_pkg::IDX_BITS-1:0]    right_index,
    input  wire logic [pbt_pkg::IDX_BITS-1:0]    amount,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pbt_pkg::VALUE_BITS-1:0]       answer,
    output logic [2:0]                           status
);

    logic                              rd_en;
    logic [pbt_pkg::ADDR_BITS-1:0]     rd_addr;
    logic [pbt_pkg::NODE_BITS-1:0]     rd_data;
    logic                              wr_en;
    logic [pbt_pkg::ADDR_BITS-1:0]     wr_addr;
    logic [pbt_pkg::NODE_BITS-1:0]     wr_data;
    pbt_pkg::result_t                  res;
    logic                              res_ready;
    logic                              out_valid_reg, out_valid_next;
    logic [pbt_pkg::VALUE_BITS-1:0]    answer_reg;
    logic [2:0]                        status_reg;

    pbt_ram #(
        .WIDTH (pbt_pkg::NODE_BITS),
        .DEPTH (pbt_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pbt_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .value       (value),
        .left_index  (left_index),
        .right_index (right_index),
        .amount      (amount),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res         (res),
        .res_ready   (res_ready)
    );

    // Output register: loads when empty or when its transfer completes.
    assign res_ready      = !out_valid_reg || out_ready;
    assign out_valid_next = res.valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            answer_reg <= res.answer;
            status_reg <= res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
